// File: rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared codes and types for the indexed list insert/delete core.
// ----------------------------------------------------------------------------
package ilid_pkg;

  // position/count width for the largest supported list
  localparam int POS_W = 11;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// File: rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot. Loads a new word, takes its left or right neighbor's word
// on an insert or delete at or below its index, or holds.
// ----------------------------------------------------------------------------
module ilid_cell import ilid_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_INS: begin
        if (MY_IDX == ctrl.pos) begin
          data_next = value;
        end else if (MY_IDX > ctrl.pos) begin
          data_next = left_data;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= ctrl.pos) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: rtl/indexed_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of up to CAPACITY words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, item_value, position) is taken at a rising edge with
//   start high and busy low. busy stays low, so a request may be issued in
//   every cycle.
//   Each request gives one result on read_value, list_length and status,
//   marked by done for exactly one cycle, in the cycle after acceptance.
//   Throughput: one request per cycle. Insert and delete move every element
//   behind the position by one cell in the same edge; the read word is
//   picked from the cell row by the registered position in the result cycle.
//   A full list or a bad position reports status and leaves the list as is.
//   Reset (rst, synchronous) empties the list and clears done; cell contents
//   are not cleared.
//   The receiver cannot stall: each result is valid for its one done cycle.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core import ilid_pkg::*; #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] item_value,
  input  logic [5:0]         position,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [5:0]         list_length,
  output logic [1:0]         status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  accept;
  logic [POS_W-1:0]      pos_ext;
  logic [POS_W-1:0]      cnt_ext;
  logic                  full;
  logic [1:0]            st_next;
  logic                  rd_ok_next;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] value_w;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] sel_data;
  logic [31:0]           sel_ext;

  logic                  rd_ok;
  logic [IW-1:0]         rd_pos;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = POS_W'(position);
  assign cnt_ext = POS_W'(count);
  assign full    = (cnt_ext == POS_W'(CAPACITY));

  generate
    if (DATA_WIDTH <= 32) begin : g_in_narrow
      assign value_w = item_value[DATA_WIDTH-1:0];
      assign sel_ext = 32'($signed(sel_data));
    end else begin : g_in_wide
      assign value_w = {{(DATA_WIDTH - 32){item_value[31]}}, item_value};
      assign sel_ext = sel_data[31:0];
    end
  endgenerate

  always_comb begin
    ctrl.op    = OP_NONE;
    ctrl.pos   = pos_ext;
    st_next    = ST_OK;
    rd_ok_next = 1'b0;
    count_next = count;
    unique case (req_type)
      REQ_APPEND: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INS;
          ctrl.pos   = cnt_ext;
          count_next = count + CW'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st_next = ST_RANGE;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INS;
          count_next = count + CW'(1);
        end
      end
      REQ_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          ctrl.op    = OP_DEL;
          count_next = count - CW'(1);
        end
      end
      REQ_READ: begin
        if (pos_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          rd_ok_next = 1'b1;
        end
      end
      default: st_next = ST_OK;
    endcase
    if (!accept) begin
      ctrl.op = OP_NONE;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end
      ilid_cell #(
        .IDX        (gi),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .value      (value_w),
        .left_data  (left_w),
        .right_data (right_w),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | (cell_data[i] & {DATA_WIDTH{rd_pos == IW'(i)}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
        rd_ok <= rd_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pos      <= IW'(position);
      list_length <= 6'(count_next);
      status      <= st_next;
    end
  end

  assign read_value = rd_ok ? sel_ext : 32'sd0;

endmodule
